// ===== hdl/first_fit_block_allocator_top_macros.svh =====
// Assertion macros for the first-fit block allocator.
// No dependencies; included by the modules that carry assertions.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define FFBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("ffba assertion failed");
// Clocked check that also holds during reset.
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("ffba assertion failed");
`else
`define FFBA_ASSERT(lbl, clk, rst_n, prop)
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffba_ctrl, the top level and the testbench.
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 24;

	localparam int ADDR_W  = 48;
	localparam int SIZE_W  = 32;
	localparam int BSIZE_W = 33;
	localparam int PG_W    = 34;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_REUSED   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_GROWN    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_REFUSED  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
	localparam logic [STAT_W-1:0] STAT_FREED    = 3'd5;
	localparam logic [STAT_W-1:0] STAT_NULL     = 3'd6;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd7;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [BSIZE_W-1:0] size;
		logic               free;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		entry_t             wr_data;
	} ram_req_t;

	typedef struct packed {
		logic               vld;
		logic [ADDR_W-1:0]  addr;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

// ===== hdl/ffba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Sequencer for the allocator: scans the block table in the RAM, decides the
// result and writes back the touched entry. Depends on ffba_pkg and the macros.
`include "first_fit_block_allocator_top_macros.svh"

module ffba_ctrl import ffba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	input  logic [ADDR_W-1:0] fresh_region,
	output logic              idle,
	output res_t              res,
	input  logic              res_take,
	output ram_req_t          ram_req,
	input  entry_t            rd_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [BSIZE_W-1:0] ALIGN_MASK = ~BSIZE_W'(7);
	localparam logic [PG_W-1:0]    PG_ADD     = PG_W'(HEADER_BYTES + PAGE_BYTES - 1);
	localparam logic [PG_W-1:0]    PG_MASK    = ~PG_W'(PAGE_BYTES - 1);

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               op_q;
	logic [BSIZE_W-1:0] rounded_q;
	logic [PG_W-1:0]    pg_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  region_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [STAT_W-1:0]  res_status_q;

	logic [BSIZE_W-1:0] rounded;
	logic [ADDR_W-1:0]  entry_payload;
	logic [PG_W-1:0]    grow_bytes;
	logic               hit;
	logic               scan_hit;
	logic               miss;
	logic               grow_ok;
	logic               issue;

	assign rounded       = (BSIZE_W'(request_size) + BSIZE_W'(7)) & ALIGN_MASK;
	assign entry_payload = rd_data.base + ADDR_W'(HEADER_BYTES);
	assign grow_bytes    = (pg_q & PG_MASK) - PG_W'(HEADER_BYTES);

	always_comb begin
		if (op_q == OP_FREE) begin
			hit = (entry_payload == addr_q);
		end else begin
			hit = rd_data.free && (rd_data.size >= rounded_q);
		end
	end

	assign scan_hit = (state_q == S_SCAN) && vld_s1 && hit;
	assign miss     = (state_q == S_SCAN) && !vld_s1 && (rd_idx_q == count_q);
	assign grow_ok  = (op_q == OP_ALLOC) && (region_q != '0)
		&& (count_q != CNT_W'(MAX_BLOCKS));
	assign issue    = (state_q == S_SCAN) && (rd_idx_q < count_q) && !scan_hit;

	always_comb begin
		ram_req.rd_en   = issue;
		ram_req.rd_addr = rd_idx_q[IDX_W-1:0];
		ram_req.wr_en   = scan_hit || (miss && grow_ok);
		if (scan_hit) begin
			ram_req.wr_addr      = idx_s1;
			ram_req.wr_data.base = rd_data.base;
			ram_req.wr_data.size = rd_data.size;
			ram_req.wr_data.free = op_q;
		end else begin
			ram_req.wr_addr      = count_q[IDX_W-1:0];
			ram_req.wr_data.base = region_q;
			ram_req.wr_data.size = grow_bytes[BSIZE_W-1:0];
			ram_req.wr_data.free = 1'b0;
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res.vld    = (state_q == S_DONE);
	assign res.addr   = res_addr_q;
	assign res.status = res_status_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					vld_s1   <= 1'b0;
					if (start) begin
						if ((operation == OP_ALLOC && request_size == '0)
							|| (operation == OP_FREE && payload_address == '0)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					// issue is low on a hit, so the read stage empties
					vld_s1 <= issue;
					if (scan_hit) begin
						state_q <= S_DONE;
					end else if (miss) begin
						state_q <= S_DONE;
						if (grow_ok) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == S_PREP) begin
			pg_q <= PG_W'(rounded_q) + PG_ADD;
		end
		if (idle && start) begin
			op_q      <= operation;
			rounded_q <= rounded;
			addr_q    <= payload_address;
			region_q  <= fresh_region;
			res_addr_q <= '0;
			if (operation == OP_ALLOC) begin
				res_status_q <= STAT_ZERO;
			end else begin
				res_status_q <= STAT_NULL;
			end
		end
		if (scan_hit) begin
			if (op_q == OP_FREE) begin
				res_addr_q   <= '0;
				res_status_q <= STAT_FREED;
			end else begin
				res_addr_q   <= entry_payload;
				res_status_q <= STAT_REUSED;
			end
		end else if (miss) begin
			if (op_q == OP_FREE) begin
				res_addr_q   <= '0;
				res_status_q <= STAT_NOTFOUND;
			end else if (region_q == '0) begin
				res_addr_q   <= '0;
				res_status_q <= STAT_REFUSED;
			end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
				res_addr_q   <= '0;
				res_status_q <= STAT_FULL;
			end else begin
				res_addr_q   <= region_q + ADDR_W'(HEADER_BYTES);
				res_status_q <= STAT_GROWN;
			end
		end
	end

	`FFBA_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_BLOCKS))
	`FFBA_ASSERT(a_wr_in_scan, clk, arst_n, ram_req.wr_en |-> state_q == S_SCAN)
	`FFBA_ASSERT(a_s1_in_table, clk, arst_n, vld_s1 |-> CNT_W'(idx_s1) < count_q)

endmodule

// ===== hdl/first_fit_block_allocator_top.sv =====
// First-fit block allocator, top level: request port, block table RAM,
// sequencer and result register. Depends on ffba_pkg, ffba_ram, ffba_ctrl.

// An allocate beat (operation 0) rounds request_size up to 8 bytes and
// takes the first free table entry, in table order, whose usable size is
// large enough; it returns base plus the header size with status reused.
// If none fits, a new entry is appended at fresh_region, sized to whole
// pages including the header, and returned with status grown; a zero
// fresh_region gives refused, a full table (64 entries) gives table full,
// and a zero size gives zero size at once. A free beat (operation 1)
// marks the lowest entry whose payload address matches as free (freed);
// a null address gives null ignored, no match gives not found. Free
// blocks are never merged. One request is in flight at a time: req_ready
// is high whenever the sequencer is idle, even while the previous result
// still waits in the output register. Zero-size and null requests skip
// the scan; any other request scans the table, reading one table entry
// per cycle from the single read port of the table RAM. The table needs
// no clearing pass after reset; only entries below the fill count are
// ever read.
module first_fit_block_allocator_top import ffba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              operation,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	input  logic [ADDR_W-1:0] fresh_region,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [ADDR_W-1:0] result_address,
	output logic [STAT_W-1:0] status
);

	logic     idle;
	logic     start;
	logic     res_take;
	res_t     res;
	ram_req_t ram_req;
	entry_t   rd_data;

	logic               rsp_valid_q;
	logic [ADDR_W-1:0]  result_address_q;
	logic [STAT_W-1:0]  status_q;

	assign req_ready = idle;
	assign start     = req_valid && req_ready;

	// result register frees the sequencer as soon as the beat is parked
	assign res_take = res.vld && (!rsp_valid_q || rsp_ready);

	ffba_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.operation       (operation),
		.request_size    (request_size),
		.payload_address (payload_address),
		.fresh_region    (fresh_region),
		.idle            (idle),
		.res             (res),
		.res_take        (res_take),
		.ram_req         (ram_req),
		.rd_data         (rd_data)
	);

	// block table: base, usable size, free mark per entry
	ffba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result_address_q <= res.addr;
			status_q         <= res.status;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign result_address = result_address_q;
	assign status         = status_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for first_fit_block_allocator_top.
// Depends on ffba_pkg and the allocator RTL; holds its own shadow of the block
// table, predicts every reply and checks it against the response port.
`timescale 1ns / 100ps

module tb;
	import ffba_pkg::*;

	localparam int RANDOM_ITEMS = 2000;
	localparam int TAIL_ITEMS   = 200;   // final stretch with no idling on either side
	localparam int DRAIN_CYCLES = 100;   // > one full table scan plus overhead

	// one predicted reply
	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] status;
	} reply_t;

	// Shadow of the block table: predicts the reply for each accepted request
	// and keeps the replies still owed by the DUT, oldest first.
	class heap_table_scoreboard;
		logic [ADDR_W-1:0]  base_of [MAX_BLOCKS];
		logic [BSIZE_W-1:0] usable [MAX_BLOCKS];
		bit                 is_free [MAX_BLOCKS];
		int unsigned        used_entries;
		reply_t             replies[$];
		int unsigned        errors;

		function logic [ADDR_W-1:0] payload_at(int unsigned k);
			logic [ADDR_W-1:0] p;
			p = base_of[k] + ADDR_W'(HEADER_BYTES);   // wraps at 48 bits
			return p;
		endfunction

		function void push_reply(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] st);
			reply_t r;
			r.addr   = addr;
			r.status = st;
			replies.push_back(r);
		endfunction

		function void note_request(logic op, logic [SIZE_W-1:0] req_size,
				logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] region);
			longint unsigned rounded;
			longint unsigned span;
			int unsigned k;
			if (op == OP_FREE) begin
				if (addr == '0) begin
					push_reply('0, STAT_NULL);
					return;
				end
				// lowest matching entry wins, already free or not
				for (k = 0; k < used_entries; k++) begin
					if (payload_at(k) == addr) begin
						is_free[k] = 1'b1;
						push_reply('0, STAT_FREED);
						return;
					end
				end
				push_reply('0, STAT_NOTFOUND);
				return;
			end
			if (req_size == '0) begin
				push_reply('0, STAT_ZERO);
				return;
			end
			rounded = 64'(req_size);
			rounded = (rounded + 64'd7) & ~64'd7;
			for (k = 0; k < used_entries; k++) begin
				if (is_free[k] && usable[k] >= rounded) begin
					is_free[k] = 1'b0;
					push_reply(payload_at(k), STAT_REUSED);
					return;
				end
			end
			// growth needed: refusal is checked before a full table
			if (region == '0) begin
				push_reply('0, STAT_REFUSED);
				return;
			end
			if (used_entries >= MAX_BLOCKS) begin
				push_reply('0, STAT_FULL);
				return;
			end
			span = ((rounded + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
			k = used_entries;
			base_of[k] = region;
			usable[k]  = BSIZE_W'(span - HEADER_BYTES);
			is_free[k] = 1'b0;
			used_entries++;
			push_reply(payload_at(k), STAT_GROWN);
		endfunction

		function void check_reply(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] st);
			reply_t want;
			if (replies.size() == 0) begin
				$display("%0t: reply with none outstanding, result_address %h status %0d",
					$time, addr, st);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (addr !== want.addr) begin
				$display("%0t: result_address expected %h, got %h", $time, want.addr, addr);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, st);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              operation = OP_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] payload_address = '0;
	logic [ADDR_W-1:0] fresh_region = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [ADDR_W-1:0] result_address;
	logic [STAT_W-1:0] status;

	heap_table_scoreboard heap = new;

	bit          req_gaps;           // request side may idle; driver-only
	bit          tail_calm = 1'b0;   // set for the last stretch, read by the reply side
	int unsigned rsp_mode_left;
	bit          rsp_stalls;
	int unsigned stall_left;

	first_fit_block_allocator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.operation      (operation),
		.request_size   (request_size),
		.payload_address(payload_address),
		.fresh_region   (fresh_region),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.result_address (result_address),
		.status         (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Drives one request beat, called at a rising edge. An optional idle burst
	// goes first; then valid stays up with a fixed payload until accepted.
	// The shadow table is updated on acceptance, so the next random beat can
	// pick addresses the DUT really handed out.
	task automatic send_request(input logic op, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] pa, input logic [ADDR_W-1:0] fr);
		if (req_gaps && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_valid       <= 1'b1;
		operation       <= op;
		request_size    <= sz;
		payload_address <= pa;
		fresh_region    <= fr;
		do @(posedge clk); while (!req_ready);
		heap.note_request(op, sz, pa, fr);
	endtask

	// Random beat. Allocations lean on small sizes and on sizes right around
	// an existing block's capacity, so the first-fit compare is hit at its
	// edges; frees mostly hand back addresses that the DUT returned earlier.
	// Full-width random values keep every input bit toggling.
	task automatic random_request();
		logic              op;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] pa;
		logic [ADDR_W-1:0] fr;
		int unsigned       pick;
		int unsigned       k;
		op   = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
		sz   = $urandom;
		pa   = {16'($urandom), 32'($urandom)};
		fr   = {16'($urandom), 32'($urandom)};
		pick = $urandom_range(0, 99);
		k    = (heap.used_entries != 0) ? $urandom_range(0, heap.used_entries - 1) : 0;
		if (op == OP_ALLOC) begin
			if (pick < 3)
				sz = '0;
			else if (pick < 45)
				sz = $urandom_range(1, 256);
			else if (pick < 70)
				sz = $urandom_range(1, 16384);
			else if (pick < 85 && heap.used_entries != 0)
				sz = SIZE_W'(heap.usable[k] + 33'($urandom_range(0, 15)) - 33'd8);
			// otherwise keep the full-range random size
			pick = $urandom_range(0, 99);
			if (pick < 10)
				fr = '0;
			else if (pick < 18 && heap.used_entries != 0)
				fr = heap.base_of[k];   // duplicate payload address
			else if (pick < 60)
				fr[11:0] = '0;          // page aligned, like a real grant
		end else begin
			if (pick < 8)
				pa = '0;
			else if (pick < 75 && heap.used_entries != 0)
				pa = heap.payload_at(k);
			else if (pick < 85 && heap.used_entries != 0)
				pa = heap.payload_at(k) + ADDR_W'($urandom_range(1, 16)) - ADDR_W'(8);
		end
		send_request(op, sz, pa, fr);
	endtask

	// Stimulus: reset, directed corner cases, random traffic, drain, verdict.
	initial begin
		int unsigned n;
		int unsigned mode_left;
		req_gaps = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; the table starts empty.
		send_request(OP_ALLOC, 32'd0, 48'd0, 48'h0000_0000_1000);        // zero size
		send_request(OP_FREE, 32'd5, 48'd0, 48'd0);                      // null free
		send_request(OP_FREE, 32'd0, 48'hFFFF_FFFF_FFFF, 48'd0);         // unknown address
		send_request(OP_ALLOC, 32'd1, 48'd0, 48'd0);                     // growth refused
		send_request(OP_ALLOC, 32'd1, 48'd0, 48'h0000_0000_1000);        // grown, one page
		send_request(OP_ALLOC, 32'd4072, 48'd0, 48'h0000_0010_0000);     // block busy: grow
		send_request(OP_FREE, 32'd0, 48'h0000_0000_1018, 48'd0);
		send_request(OP_FREE, 32'd0, 48'h0000_0000_1018, 48'd0);         // double free
		send_request(OP_ALLOC, 32'd4072, 48'd0, 48'd0);                  // exact fit, reused
		send_request(OP_FREE, 32'd0, 48'h0000_0000_1018, 48'd0);
		// one byte too many for the free page: grows, payload wraps past 2^48
		send_request(OP_ALLOC, 32'd4073, 48'd0, 48'hFFFF_FFFF_FFF0);
		// largest request rounds to 2^32 without overflow
		send_request(OP_ALLOC, 32'hFFFF_FFFF, 48'd0, 48'h8000_0000_0000);
		send_request(OP_FREE, 32'd0, 48'h0000_0000_0008, 48'd0);
		send_request(OP_FREE, 32'd0, 48'h8000_0000_0018, 48'd0);
		send_request(OP_ALLOC, 32'hFFFF_FFF9, 48'd0, 48'd0);            // skips small blocks
		// no fit, grows at an existing base: two entries share a payload address
		send_request(OP_ALLOC, 32'd8169, 48'd0, 48'h0000_0000_1000);
		send_request(OP_FREE, 32'd0, 48'h0000_0000_1018, 48'd0);         // lowest match freed
		send_request(OP_ALLOC, 32'd4000, 48'd0, 48'd0);
		send_request(OP_ALLOC, 32'd1, 48'd0, 48'd0);                     // reuses the one free block
		send_request(OP_FREE, 32'd0, 48'h0000_0000_1010, 48'd0);         // near miss

		// Random part: the table fills within the first few hundred beats, so
		// most traffic runs full-length scans and hits the table-full path.
		mode_left = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(50, 300);
				req_gaps  = $urandom_range(0, 2) != 0;
			end else begin
				mode_left--;
			end
			if (n >= RANDOM_ITEMS - TAIL_ITEMS) begin
				req_gaps = 1'b0;
				tail_calm <= 1'b1;
			end
			random_request();
		end
		req_valid <= 1'b0;

		while (heap.replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (heap.errors == 0 && heap.replies.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Reply side: check every accepted beat, then pick the next ready value.
	// Stalls come in bursts, in stretches chosen at random between stalling
	// and calm, and stop in the final stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				heap.check_reply(result_address, status);
			if (rsp_mode_left == 0) begin
				rsp_mode_left = $urandom_range(100, 1500);
				rsp_stalls    = $urandom_range(0, 2) != 0;
			end else begin
				rsp_mode_left--;
			end
			if (stall_left != 0)
				stall_left--;
			else if (rsp_stalls && !tail_calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			rsp_ready <= (stall_left == 0);
		end
	end

	// Watchdog: fails the run if the stimulus never finishes.
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator_top.sv
bench/tb.sv
